>>> design/hidp_pkg.sv
// Package for the HID report descriptor item parser.
// Holds the parsed-item transaction type, item tag constants and the
// sign-extension helper. No dependencies.
`timescale 1ns / 1ps

package hidp_pkg;

    // Collection depth counter width and its hard ceiling.
    localparam int DEPTH_W     = 4;
    localparam int DEPTH_LIMIT = 15;

    // Entries in the queue between the byte parser and the result stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [7:0] PREFIX_LONG  = 8'hFE;
    localparam logic [7:0] TAG_MASK     = 8'hFC;
    localparam logic [1:0] SIZE_CODE_4  = 2'h3;
    localparam logic [7:0] TAG_COLL     = 8'hA0;
    localparam logic [7:0] TAG_END_COLL = 8'hC0;
    localparam logic [7:0] TAG_LOG_MIN  = 8'h14;
    localparam logic [7:0] TAG_LOG_MAX  = 8'h24;
    localparam logic [7:0] TAG_PHY_MIN  = 8'h34;
    localparam logic [7:0] TAG_PHY_MAX  = 8'h44;

    // One event handed from the byte parser to the result stage.
    // A short event carries a completed short item; otherwise the event
    // only marks the end of the descriptor (a long item closed by the
    // final byte, or a truncated item).
    typedef struct packed {
        logic        is_short;
        logic        truncated;
        logic        fin;
        logic [7:0]  prefix;
        logic [31:0] data;
    } hidp_event_t;

    // Number of data bytes selected by a prefix size code.
    function automatic logic [2:0] size_bytes(input logic [1:0] code);
        logic [2:0] n;
        begin
            n = (code == SIZE_CODE_4) ? 3'd4 : {1'b0, code};
            return n;
        end
    endfunction

    // Sign-extend item data from its byte count; zero for an empty item.
    function automatic logic [31:0] sign_extend(input logic [1:0] code,
                                                input logic [31:0] v);
        logic [31:0] r;
        begin
            case (code)
                2'd1:    r = {{24{v[7]}}, v[7:0]};
                2'd2:    r = {{16{v[15]}}, v[15:0]};
                2'd3:    r = v;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> design/hid_descriptor_item_parser.sv
// HID report descriptor item parser, top level. Depends on hidp_pkg,
// hidp_front, hidp_queue and hidp_back.
// Throughput: one descriptor byte per cycle, sustained while results are taken.
// The event for a completed item is written into the queue, then into the output register.
// Reset: rst_n clears parser phase, queue pointers, depth and output valid.
`timescale 1ns / 1ps

module hid_descriptor_item_parser #(
    parameter int MAX_DEPTH = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    // Descriptor byte channel.
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         desc_byte,
    input  logic               final_byte,
    // Parsed item channel.
    output logic               item_valid,
    input  logic               item_stall,
    output logic [1:0]         item_type,
    output logic [7:0]         item_tag,
    output logic [2:0]         data_bytes,
    output logic [31:0]        raw_data,
    output logic signed [31:0] signed_data,
    output logic               is_extent_item,
    output logic [3:0]         nest_depth,
    output logic               truncated,
    output logic               end_of_descriptor
);
    import hidp_pkg::*;

    // The front end decodes one byte per accepted transaction and, when a
    // short item completes or the descriptor ends, pushes one event into
    // the queue in the same cycle. The queue lets the front keep taking
    // bytes while a result waits in the output register; the byte channel
    // stalls only once the queue is full.
    logic        take;
    logic        ev_push;
    hidp_event_t ev;
    logic        q_full;
    logic        head_valid;
    hidp_event_t head_ev;
    logic        pop;

    assign byte_stall = q_full;
    assign take       = byte_valid && !q_full;

    hidp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .desc_byte  (desc_byte),
        .final_byte (final_byte),
        .ev_push    (ev_push),
        .ev         (ev)
    );

    hidp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (ev_push),
        .push_ev    (ev),
        .full       (q_full),
        .head_valid (head_valid),
        .head_ev    (head_ev),
        .pop        (pop)
    );

    // The back end owns the collection depth: it pops one event per cycle
    // whenever its output register is empty or being drained, applies the
    // End collection decrement before the item and the Collection increment
    // after it, and clears the depth after the descriptor's final event.
    hidp_back #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_valid        (head_valid),
        .head_ev           (head_ev),
        .pop               (pop),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .item_type         (item_type),
        .item_tag          (item_tag),
        .data_bytes        (data_bytes),
        .raw_data          (raw_data),
        .signed_data       (signed_data),
        .is_extent_item    (is_extent_item),
        .nest_depth        (nest_depth),
        .truncated         (truncated),
        .end_of_descriptor (end_of_descriptor)
    );

endmodule

>>> design/hidp_front.sv
// Byte-level front end of the HID descriptor parser.
// Splits the byte stream into short items, skips long items, and emits one
// event per completed short item or descriptor end. Uses hidp_pkg.
`timescale 1ns / 1ps

module hidp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           desc_byte,
    input  logic                 final_byte,
    output logic                 ev_push,
    output hidp_pkg::hidp_event_t ev
);
    import hidp_pkg::*;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_SHORT,
        PH_LSIZE,
        PH_LSKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  prefix_reg, prefix_next;
    logic [31:0] accum_reg, accum_next;
    logic [8:0]  left_reg, left_next;
    logic [2:0]  index_reg, index_next;

    logic        done_short;
    logic        done_long;
    logic [8:0]  left_dec;
    logic [2:0]  first_size;

    assign left_dec   = (left_reg != 9'd0) ? left_reg - 9'd1 : left_reg;
    assign first_size = size_bytes(desc_byte[1:0]);

    always_comb
    begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        accum_next  = accum_reg;
        left_next   = left_reg;
        index_next  = index_reg;
        done_short  = 1'b0;
        done_long   = 1'b0;

        case (phase_reg)
            PH_PREFIX:
            begin
                prefix_next = desc_byte;
                accum_next  = 32'd0;
                index_next  = 3'd0;
                if (desc_byte == PREFIX_LONG)
                begin
                    phase_next = PH_LSIZE;
                end
                else
                begin
                    left_next = {6'd0, first_size};
                    if (first_size == 3'd0)
                        done_short = 1'b1;
                    else
                        phase_next = PH_SHORT;
                end
            end
            PH_SHORT:
            begin
                accum_next = accum_reg |
                             ({24'd0, desc_byte} << {index_reg[1:0], 3'b000});
                index_next = index_reg + 3'd1;
                left_next  = left_dec;
                if (left_dec == 9'd0)
                    done_short = 1'b1;
            end
            PH_LSIZE:
            begin
                left_next  = {1'b0, desc_byte} + 9'd1;
                phase_next = PH_LSKIP;
            end
            default:
            begin
                left_next = left_dec;
                if (left_dec == 9'd0)
                begin
                    phase_next = PH_PREFIX;
                    done_long  = 1'b1;
                end
            end
        endcase

        if (done_short)
            phase_next = PH_PREFIX;

        // The event takes the item as completed by this byte.
        ev.is_short  = done_short;
        ev.truncated = !done_short && !done_long;
        ev.fin       = final_byte;
        ev.prefix    = prefix_next;
        ev.data      = accum_next;
        ev_push      = take && (done_short || final_byte);

        // The last byte of a descriptor starts the next one from scratch.
        if (final_byte)
        begin
            phase_next  = PH_PREFIX;
            prefix_next = 8'd0;
            accum_next  = 32'd0;
            left_next   = 9'd0;
            index_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PREFIX;
            prefix_reg <= 8'd0;
            accum_reg  <= 32'd0;
            left_reg   <= 9'd0;
            index_reg  <= 3'd0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            accum_reg  <= accum_next;
            left_reg   <= left_next;
            index_reg  <= index_next;
        end
    end

endmodule

>>> design/hidp_queue.sv
// Small FIFO of parser events between the front end and the result stage.
// Register-array storage with read and write pointers. Uses hidp_pkg.
`timescale 1ns / 1ps

module hidp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hidp_pkg::hidp_event_t push_ev,
    output logic                  full,
    output logic                  head_valid,
    output hidp_pkg::hidp_event_t head_ev,
    input  logic                  pop
);
    import hidp_pkg::*;

    hidp_event_t         mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_ev    = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QUEUE_AW+1)'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - (QUEUE_AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

>>> design/hidp_back.sv
// Result stage of the HID descriptor parser.
// Tracks collection depth, decodes each event into result fields and holds
// them in an output register. Uses hidp_pkg.
`timescale 1ns / 1ps

module hidp_back #(
    parameter int MAX_DEPTH = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  hidp_pkg::hidp_event_t head_ev,
    output logic                  pop,
    output logic                  item_valid,
    input  logic                  item_stall,
    output logic [1:0]            item_type,
    output logic [7:0]            item_tag,
    output logic [2:0]            data_bytes,
    output logic [31:0]           raw_data,
    output logic signed [31:0]    signed_data,
    output logic                  is_extent_item,
    output logic [3:0]            nest_depth,
    output logic                  truncated,
    output logic                  end_of_descriptor
);
    import hidp_pkg::*;

    localparam int DEPTH_CAP_I = (MAX_DEPTH > DEPTH_LIMIT) ? DEPTH_LIMIT : MAX_DEPTH;
    localparam logic [DEPTH_W-1:0] DEPTH_CAP = DEPTH_CAP_I[DEPTH_W-1:0];

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DEPTH_W-1:0] depth_shown;
    logic               valid_reg;
    logic [7:0]         tag;
    logic               ext;

    logic [1:0]  type_reg, type_next;
    logic [7:0]  tag_reg, tag_next;
    logic [2:0]  bytes_reg, bytes_next;
    logic [31:0] raw_reg, raw_next;
    logic [31:0] sdata_reg, sdata_next;
    logic        ext_reg, ext_next;
    logic [3:0]  nest_reg;
    logic        trunc_reg, trunc_next;
    logic        eod_reg;

    assign pop = head_valid && (!valid_reg || !item_stall);
    assign tag = head_ev.prefix & TAG_MASK;
    assign ext = tag inside {TAG_LOG_MIN, TAG_LOG_MAX, TAG_PHY_MIN, TAG_PHY_MAX};

    always_comb
    begin
        depth_shown = depth_reg;
        depth_next  = depth_reg;
        type_next   = 2'd0;
        tag_next    = 8'd0;
        bytes_next  = 3'd0;
        raw_next    = 32'd0;
        sdata_next  = 32'd0;
        ext_next    = 1'b0;
        trunc_next  = 1'b0;

        if (head_ev.is_short)
        begin
            if (tag == TAG_END_COLL && depth_reg != '0)
                depth_shown = depth_reg - DEPTH_W'(1);
            depth_next = depth_shown;
            if (tag == TAG_COLL && depth_shown < DEPTH_CAP)
                depth_next = depth_shown + DEPTH_W'(1);
            type_next  = head_ev.prefix[3:2];
            tag_next   = tag;
            bytes_next = size_bytes(head_ev.prefix[1:0]);
            raw_next   = head_ev.data;
            sdata_next = sign_extend(head_ev.prefix[1:0], head_ev.data);
            ext_next   = ext;
        end
        else
        begin
            trunc_next = head_ev.truncated;
        end

        if (head_ev.fin)
            depth_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                depth_reg <= depth_next;
                valid_reg <= 1'b1;
            end
            else if (!item_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            type_reg  <= type_next;
            tag_reg   <= tag_next;
            bytes_reg <= bytes_next;
            raw_reg   <= raw_next;
            sdata_reg <= sdata_next;
            ext_reg   <= ext_next;
            nest_reg  <= depth_shown;
            trunc_reg <= trunc_next;
            eod_reg   <= head_ev.fin;
        end
    end

    assign item_valid        = valid_reg;
    assign item_type         = type_reg;
    assign item_tag          = tag_reg;
    assign data_bytes        = bytes_reg;
    assign raw_data          = raw_reg;
    assign signed_data       = sdata_reg;
    assign is_extent_item    = ext_reg;
    assign nest_depth        = nest_reg;
    assign truncated         = trunc_reg;
    assign end_of_descriptor = eod_reg;

endmodule

>>> bench/tb_hid_descriptor_item_parser.sv
// Self-checking testbench for hid_descriptor_item_parser. It sends directed and random
// descriptor byte streams and checks every parsed item against a predictor in the bench.
// Depends on hidp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_hid_descriptor_item_parser;
    import hidp_pkg::*;

    // The depth ceiling is whichever is lower: the parameter or what the 4-bit count holds.
    localparam int TB_MAX_DEPTH   = 15;
    localparam int DEPTH_CAP      = (TB_MAX_DEPTH > DEPTH_LIMIT) ? DEPTH_LIMIT : TB_MAX_DEPTH;
    localparam int RANDOM_BYTES   = 160;
    // The long result-side hold starts once this many bytes are accepted, which falls
    // in the middle of the random traffic.
    localparam int HOLD_AT        = 370;
    localparam int HOLD_CYCLES    = 80;
    // The largest stretch without a transaction in a correct run is the hold above.
    // The limit allows several times that.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 60;

    typedef enum logic [1:0] {
        EXPECT_PREFIX,
        SHORT_DATA,
        LONG_SIZE,
        LONG_SKIP
    } parse_state_t;

    // One parsed item as it should appear on the result ports.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tag;
        logic [2:0]  nbytes;
        logic [31:0] raw;
        logic [31:0] sext;
        logic        extent;
        logic [3:0]  depth;
        logic        trunc;
        logic        eod;
    } item_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_stall;
    logic [7:0]         desc_byte = 8'd0;
    logic               final_byte = 1'b0;
    logic               item_valid;
    logic               item_stall = 1'b0;
    logic [1:0]         item_type;
    logic [7:0]         item_tag;
    logic [2:0]         data_bytes;
    logic [31:0]        raw_data;
    logic signed [31:0] signed_data;
    logic               is_extent_item;
    logic [3:0]         nest_depth;
    logic               truncated;
    logic               end_of_descriptor;

    // Stimulus is stored as {final_byte, desc_byte}. The queue is filled before reset
    // is released.
    logic [8:0]   pending_bytes[$];
    logic [7:0]   stage_bytes[$];
    item_result_t expected_items[$];

    // State of the predictor. It mirrors the parser's architectural state.
    parse_state_t parse_state;
    logic [7:0]   prefix_q;
    logic [31:0]  data_q;
    logic [8:0]   remaining;
    logic [1:0]   data_pos;
    logic [3:0]   depth;

    int           errors = 0;
    int           reports = 0;
    int           bytes_accepted = 0;
    int           idle_cycles = 0;

    // Driver pacing: cycles to wait before the next byte, and a mode that turns the
    // gaps off for a while.
    logic [2:0]   send_gap = 3'd0;
    logic         send_steady = 1'b0;

    // Receiver pacing: per-result stall, the one long hold, and a mode without stalls.
    logic [2:0]   take_wait = 3'd0;
    logic         recv_steady = 1'b0;
    int           hold_left = 0;
    logic         hold_done = 1'b0;

    hid_descriptor_item_parser #(
        .MAX_DEPTH(TB_MAX_DEPTH)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .byte_valid       (byte_valid),
        .byte_stall       (byte_stall),
        .desc_byte        (desc_byte),
        .final_byte       (final_byte),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .item_type        (item_type),
        .item_tag         (item_tag),
        .data_bytes       (data_bytes),
        .raw_data         (raw_data),
        .signed_data      (signed_data),
        .is_extent_item   (is_extent_item),
        .nest_depth       (nest_depth),
        .truncated        (truncated),
        .end_of_descriptor(end_of_descriptor)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Number of data bytes that follow a short-item prefix. Size code 3 stands for
    // four bytes.
    function automatic logic [2:0] data_count(input logic [1:0] code);
        logic [2:0] n;
        begin
            case (code)
                2'd0:    n = 3'd0;
                2'd1:    n = 3'd1;
                2'd2:    n = 3'd2;
                default: n = 3'd4;
            endcase
            return n;
        end
    endfunction

    // A final byte and reset both return the parser to the start of a descriptor.
    task automatic clear_parser();
        begin
            parse_state = EXPECT_PREFIX;
            prefix_q    = 8'd0;
            data_q      = 32'd0;
            remaining   = 9'd0;
            data_pos    = 2'd0;
            depth       = 4'd0;
        end
    endtask

    // Advance the predictor by one accepted byte. Queue the item it completes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        item_result_t r;
        logic         short_done;
        logic         long_done;
        logic [7:0]   tag;
        begin
            r          = '0;
            short_done = 1'b0;
            long_done  = 1'b0;
            case (parse_state)
                EXPECT_PREFIX:
                begin
                    prefix_q = b;
                    data_q   = 32'd0;
                    data_pos = 2'd0;
                    if (b == PREFIX_LONG)
                        parse_state = LONG_SIZE;
                    else
                    begin
                        remaining = {6'd0, data_count(b[1:0])};
                        if (remaining == 9'd0)
                            short_done = 1'b1;
                        else
                            parse_state = SHORT_DATA;
                    end
                end
                SHORT_DATA:
                begin
                    // Data bytes arrive least significant first.
                    data_q   = data_q | ({24'd0, b} << (8 * data_pos));
                    data_pos = data_pos + 2'd1;
                    if (remaining != 9'd0)
                        remaining = remaining - 9'd1;
                    if (remaining == 9'd0)
                        short_done = 1'b1;
                end
                LONG_SIZE:
                begin
                    // The long tag byte is skipped together with the data bytes.
                    remaining   = {1'b0, b} + 9'd1;
                    parse_state = LONG_SKIP;
                end
                default:
                begin
                    if (remaining != 9'd0)
                        remaining = remaining - 9'd1;
                    if (remaining == 9'd0)
                    begin
                        parse_state = EXPECT_PREFIX;
                        long_done   = 1'b1;
                    end
                end
            endcase

            if (short_done)
            begin
                tag         = prefix_q & TAG_MASK;
                parse_state = EXPECT_PREFIX;
                // End collection counts as part of the outer level, so the depth drops
                // before the item is shown.
                if (tag == TAG_END_COLL && depth != 4'd0)
                    depth = depth - 4'd1;
                r.kind   = prefix_q[3:2];
                r.tag    = tag;
                r.nbytes = data_count(prefix_q[1:0]);
                r.raw    = data_q;
                case (r.nbytes)
                    3'd1:    r.sext = {{24{data_q[7]}}, data_q[7:0]};
                    3'd2:    r.sext = {{16{data_q[15]}}, data_q[15:0]};
                    3'd4:    r.sext = data_q;
                    default: r.sext = 32'd0;
                endcase
                r.extent = (tag == TAG_LOG_MIN) || (tag == TAG_LOG_MAX) ||
                           (tag == TAG_PHY_MIN) || (tag == TAG_PHY_MAX);
                r.depth  = depth;
                r.eod    = fin;
                // A collection is shown at the outer level and opens a new level after it.
                if (tag == TAG_COLL && depth < DEPTH_CAP)
                    depth = depth + 4'd1;
                expected_items.push_back(r);
            end
            else if (fin)
            begin
                // The descriptor ends without a completed short item. The result is
                // either a clean end after a long item or a truncation.
                r.depth = depth;
                r.trunc = !long_done;
                r.eod   = 1'b1;
                expected_items.push_back(r);
            end
            if (fin)
                clear_parser();
        end
    endtask

    // Stage a short item: the prefix, then as many data bytes as its size code asks.
    task automatic stage_short(input logic [7:0] prefix, input logic [31:0] data);
        int n;
        begin
            n = data_count(prefix[1:0]);
            stage_bytes.push_back(prefix);
            for (int i = 0; i < n; i++)
                stage_bytes.push_back(data[8 * i +: 8]);
        end
    endtask

    // Stage a long item: the long prefix, the data size, a long tag and the data.
    task automatic stage_long(input int dsize);
        begin
            stage_bytes.push_back(PREFIX_LONG);
            stage_bytes.push_back(dsize[7:0]);
            stage_bytes.push_back($urandom_range(0, 255));
            for (int i = 0; i < dsize; i++)
                stage_bytes.push_back($urandom_range(0, 255));
        end
    endtask

    // Move the first count staged bytes to the driver. Optionally mark the last one
    // as final.
    task automatic flush_stage(input int count, input logic fin_last);
        begin
            for (int i = 0; i < count; i++)
                pending_bytes.push_back({fin_last && (i == count - 1), stage_bytes[i]});
            stage_bytes.delete();
        end
    endtask

    // Stage a well-formed descriptor with random content. The mix leans toward
    // collections and extent items, so that depth tracking and the extent flag see
    // plenty of traffic. Now and then a deep nest pushes the depth up against its ceiling.
    task automatic stage_descriptor();
        int n_items;
        int nest;
        int sel;
        logic [7:0] prefix;
        begin
            n_items = $urandom_range(1, 10);
            if ($urandom_range(0, 7) == 0)
            begin
                nest = $urandom_range(DEPTH_CAP + 1, DEPTH_CAP + 3);
                repeat (nest) stage_short(TAG_COLL, 32'd0);
                repeat (nest) stage_short(TAG_END_COLL, 32'd0);
            end
            repeat (n_items)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 15)
                    stage_short(TAG_COLL | $urandom_range(0, 3), $urandom);
                else if (sel < 28)
                    stage_short(TAG_END_COLL | $urandom_range(0, 3), $urandom);
                else if (sel < 45)
                begin
                    case ($urandom_range(0, 3))
                        0:       prefix = TAG_LOG_MIN;
                        1:       prefix = TAG_LOG_MAX;
                        2:       prefix = TAG_PHY_MIN;
                        default: prefix = TAG_PHY_MAX;
                    endcase
                    stage_short(prefix | $urandom_range(0, 3), $urandom);
                end
                else if (sel < 90)
                begin
                    prefix = $urandom_range(0, 255);
                    if (prefix == PREFIX_LONG)
                        prefix = TAG_MASK;
                    stage_short(prefix, $urandom);
                end
                else
                    stage_long($urandom_range(0, 5));
            end
        end
    endtask

    // Compare one field. A mismatch is reported, up to a cap on the number of lines.
    function automatic logic field_differs(input string name, input logic [31:0] want,
                                           input logic [31:0] got);
        logic differs;
        begin
            differs = (want !== got);
            if (differs && reports < MAX_REPORTS)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                reports++;
            end
            return differs;
        end
    endfunction

    // Check the result transaction on the ports against the oldest expected item.
    task automatic check_result();
        item_result_t want;
        logic         bad;
        begin
            if (expected_items.size() == 0)
            begin
                if (reports < MAX_REPORTS)
                begin
                    $display("%0t: unexpected item, expected none, actual tag 0x%0h eod %0b",
                             $time, item_tag, end_of_descriptor);
                    reports++;
                end
                errors++;
            end
            else
            begin
                want = expected_items.pop_front();
                bad  = 1'b0;
                bad  = bad | field_differs("item_type", want.kind, item_type);
                bad  = bad | field_differs("item_tag", want.tag, item_tag);
                bad  = bad | field_differs("data_bytes", want.nbytes, data_bytes);
                bad  = bad | field_differs("raw_data", want.raw, raw_data);
                bad  = bad | field_differs("signed_data", want.sext, signed_data);
                bad  = bad | field_differs("is_extent_item", want.extent, is_extent_item);
                bad  = bad | field_differs("nest_depth", want.depth, nest_depth);
                bad  = bad | field_differs("truncated", want.trunc, truncated);
                bad  = bad | field_differs("end_of_descriptor", want.eod, end_of_descriptor);
                if (bad)
                    errors++;
            end
        end
    endtask

    // Byte-side driver. Each accepted transaction goes to the predictor. A new byte is
    // loaded only when the slot is free, so a stalled byte stays unchanged. Every byte
    // draws the gap that comes before its successor.
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        logic [8:0] next_byte;
        if (!rst_n)
        begin
            byte_valid  <= 1'b0;
            desc_byte   <= 8'd0;
            final_byte  <= 1'b0;
            send_gap    <= 3'd0;
            send_steady <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                parse_byte(desc_byte, final_byte);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!byte_valid || !byte_stall)
            begin
                if (send_gap != 3'd0)
                begin
                    byte_valid <= 1'b0;
                    send_gap   <= send_gap - 3'd1;
                end
                else if (pending_bytes.size() != 0)
                begin
                    next_byte  = pending_bytes.pop_front();
                    desc_byte  <= next_byte[7:0];
                    final_byte <= next_byte[8];
                    byte_valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        send_steady <= !send_steady;
                    send_gap <= send_steady ? 3'd0 : $urandom_range(0, 4);
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // Item-side monitor. It checks each accepted result. After each result it draws a
    // random stall. Once, midway through the random traffic, it holds off for
    // a long stretch, so the parser's internal queue fills and it stalls the byte side.
    always @(posedge clk or negedge rst_n)
    begin : item_monitor
        logic [2:0] wait_next;
        if (!rst_n)
        begin
            item_stall  <= 1'b0;
            take_wait   <= 3'd0;
            recv_steady <= 1'b0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end
        else
        begin
            wait_next = take_wait;
            if (item_valid && !item_stall)
            begin
                check_result();
                if ($urandom_range(0, 15) == 0)
                    recv_steady <= !recv_steady;
                wait_next = recv_steady ? 3'd0 : $urandom_range(0, 4);
            end
            if (hold_left != 0)
            begin
                item_stall <= 1'b1;
                hold_left  <= hold_left - 1;
            end
            else if (!hold_done && bytes_accepted >= HOLD_AT)
            begin
                item_stall <= 1'b1;
                hold_left  <= HOLD_CYCLES - 1;
                hold_done  <= 1'b1;
            end
            else if (wait_next != 3'd0)
            begin
                item_stall <= 1'b1;
                wait_next  = wait_next - 3'd1;
            end
            else
                item_stall <= 1'b0;
            take_wait <= wait_next;
        end
    end

    // The watchdog ends the run when neither channel has moved a transaction for too long.
    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (item_valid && !item_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int base;
        int sel;
        int k;
        clear_parser();

        // Directed part. It covers all four item types, the extremes of every data
        // size, end collection at depth zero, the reserved prefixes and a long item
        // in mid-stream.
        stage_short(8'h00, 32'h0);
        stage_short(8'h15, 32'h80);
        stage_short(8'h26, 32'h7FFF);
        stage_short(8'h47, 32'hFFFF_FFFF);
        stage_short(TAG_END_COLL, 32'h0);
        stage_short(8'hA1, 32'h01);
        stage_short(8'h08, 32'h0);
        stage_bytes.push_back(PREFIX_LONG);
        stage_bytes.push_back(8'h00);
        stage_bytes.push_back(8'h10);
        stage_short(8'hFD, 32'h34);
        stage_short(8'hFF, 32'h7FFF_FFFF);
        stage_short(8'hFC, 32'h0);
        flush_stage(stage_bytes.size(), 1'b0);
        // Truncation inside a short item, with the depth still at one.
        stage_short(8'h81, 32'h0);
        flush_stage(1, 1'b1);
        // A zero-size item that carries the final byte.
        stage_short(8'h04, 32'h0);
        flush_stage(1, 1'b1);
        // A long item closed by the final byte.
        stage_bytes.push_back(PREFIX_LONG);
        stage_bytes.push_back(8'h01);
        stage_bytes.push_back(8'h22);
        stage_bytes.push_back(8'h55);
        flush_stage(4, 1'b1);
        // Truncation right after a long prefix.
        stage_bytes.push_back(PREFIX_LONG);
        flush_stage(1, 1'b1);

        // The largest long item. The full 9-bit skip count is exercised once.
        stage_long(255);
        stage_short(8'h00, 32'h0);
        flush_stage(stage_bytes.size(), 1'b1);

        // Random part. Most of it is well-formed descriptors. The rest is descriptors
        // cut at a random byte, and short bursts of noise that always end on a final
        // byte, so that the next descriptor starts clean.
        base = pending_bytes.size();
        while (pending_bytes.size() - base < RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
            begin
                stage_descriptor();
                flush_stage(stage_bytes.size(), 1'b1);
            end
            else if (sel < 90)
            begin
                stage_descriptor();
                flush_stage($urandom_range(1, stage_bytes.size()), 1'b1);
            end
            else
            begin
                k = $urandom_range(1, 8);
                for (int i = 0; i < k; i++)
                    pending_bytes.push_back({(i == k - 1) || ($urandom_range(0, 5) == 0),
                                             8'($urandom_range(0, 255))});
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until all stimulus is accepted and every expected item has arrived.
        // Then wait for DRAIN_CYCLES, in which any extra item would show up.
        while (pending_bytes.size() != 0 || byte_valid)
            @(posedge clk);
        while (expected_items.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
